@@ hw/rtl/wtsp_pkg.sv @@
// Shared types and constants of the world-to-screen projection block.
package wtsp_pkg;

    localparam int COORD_W   = 32;
    localparam int CFG_W     = 64;
    localparam int NUM_PAIRS = 8;
    localparam int IDX_W     = 4;
    localparam int PROD_W    = 48;
    localparam int CLIP_W    = 50;
    localparam int MAG_W     = 48;
    localparam int NUM_W     = 64;
    localparam int QUOT_W    = 41;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam logic signed [CLIP_W-1:0] W_MIN = 50'sd6554;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
    } point_t;

    typedef struct packed {
        logic                      visible;
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
    } result_t;

    typedef struct packed {
        logic                     visible;
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cw;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t data;
    } qpush_t;

endpackage

@@ hw/rtl/wtsp_front.sv @@
// Front end: input register, matrix products and row sums with visibility test.
module wtsp_front
    import wtsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] coeff_pair [NUM_PAIRS],
    input  logic             push,
    output logic             full,
    input  point_t           point,
    output qpush_t           q_req,
    input  logic             q_room
);

    logic                      f0_valid_reg;
    logic                      f1_valid_reg;
    logic                      f2_valid_reg;
    point_t                    f0_point_reg;
    logic signed [PROD_W-1:0]  prod_reg [3][3];
    logic signed [COORD_W-1:0] trans_reg [3];
    logic signed [PROD_W-1:0]  prod_next [3][3];
    logic signed [COORD_W-1:0] trans_next [3];
    logic signed [CLIP_W-1:0]  sum_reg [3];
    logic signed [CLIP_W-1:0]  sum_next [3];
    logic                      en;

    function automatic logic signed [COORD_W-1:0] coef(
        input logic [CFG_W-1:0] pairs [NUM_PAIRS], input int idx);
        logic [CFG_W-1:0] p;
        p = pairs[idx / 2];
        return (idx % 2 == 1) ? p[CFG_W-1:COORD_W] : p[COORD_W-1:0];
    endfunction

    function automatic int row_of(input int j);
        return (j == 2) ? 3 : j;
    endfunction

    assign en   = !(f2_valid_reg && !q_room);
    assign full = !en;

    always_comb
    begin
        logic signed [2*COORD_W-1:0] p;
        logic signed [COORD_W-1:0]   c [3];
        c[0] = f0_point_reg.world_x;
        c[1] = f0_point_reg.world_y;
        c[2] = f0_point_reg.world_z;
        p    = '0;
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p = c[k] * coef(coeff_pair, row_of(j) * 4 + k);
                prod_next[j][k] = p[2*COORD_W-1:16];
            end
            trans_next[j] = coef(coeff_pair, row_of(j) * 4 + 3);
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum_next[j] = CLIP_W'(prod_reg[j][0]) + CLIP_W'(prod_reg[j][1])
                        + CLIP_W'(prod_reg[j][2]) + CLIP_W'(trans_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f0_valid_reg <= push;
            f1_valid_reg <= f0_valid_reg;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_point_reg <= point;
            prod_reg     <= prod_next;
            trans_reg    <= trans_next;
            sum_reg      <= sum_next;
        end
    end

    assign q_req.valid        = f2_valid_reg && en;
    assign q_req.data.cx      = sum_reg[0];
    assign q_req.data.cy      = sum_reg[1];
    assign q_req.data.cw      = sum_reg[2];
    assign q_req.data.visible = !(sum_reg[2] < W_MIN);

endmodule

@@ hw/rtl/wtsp_queue.sv @@
// Short queue that decouples the front end from the divide back end.
module wtsp_queue
    import wtsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  qpush_t q_req,
    output logic   q_room,
    output qent_t  q_head,
    output logic   q_avail,
    input  logic   q_pop
);

    qent_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign q_avail = count_reg != '0;
    assign do_pop  = q_pop && q_avail;
    assign q_room  = (count_reg != QCNT_W'(QDEPTH)) || do_pop;
    assign q_head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + QCNT_W'(q_req.valid) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_req.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_req.valid)
        begin
            mem_reg[wr_ptr_reg] <= q_req.data;
        end
    end

endmodule

@@ hw/rtl/wtsp_back.sv @@
// Back end: pipelined restoring divide, clamping, screen mapping and result register.
module wtsp_back
    import wtsp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  qent_t   q_head,
    input  logic    q_avail,
    output logic    q_pop,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    localparam int HW = SCREEN_WIDTH / 2;
    localparam int HH = SCREEN_HEIGHT / 2;
    localparam int EXT_W = MAG_W + QUOT_W;
    localparam int PRD_W = 58;
    localparam int SUM_W = PRD_W + 1;
    localparam logic signed [15:0] KX = 16'(HW + 1);
    localparam logic signed [15:0] KY = 16'(1 - HH);
    localparam logic signed [SUM_W-1:0] OFF_X = SUM_W'(HW * 65536);
    localparam logic signed [SUM_W-1:0] OFF_Y = SUM_W'(HH * 65536);
    localparam logic signed [SUM_W-1:0] SMAX = 59'sd2147483647;
    localparam logic signed [SUM_W-1:0] SMIN = -59'sd2147483648;
    localparam logic [QUOT_W-1:0] LIMIT = QUOT_W'(1) << (QUOT_W - 1);

    logic en;

    logic             b0_valid_reg;
    logic             b0_vis_reg;
    logic             b0_negx_reg;
    logic             b0_negy_reg;
    logic [MAG_W-1:0] b0_nx_reg;
    logic [MAG_W-1:0] b0_ny_reg;
    logic [MAG_W-1:0] b0_d_reg;

    logic              dv_valid_reg [QUOT_W+1];
    logic              dv_vis_reg   [QUOT_W+1];
    logic              dv_negx_reg  [QUOT_W+1];
    logic              dv_negy_reg  [QUOT_W+1];
    logic              dv_ovfx_reg  [QUOT_W+1];
    logic              dv_ovfy_reg  [QUOT_W+1];
    logic [MAG_W-1:0]  dv_d_reg     [QUOT_W+1];
    logic [NUM_W-1:0]  dv_rx_reg    [QUOT_W+1];
    logic [NUM_W-1:0]  dv_ry_reg    [QUOT_W+1];
    logic [QUOT_W-1:0] dv_qx_reg    [QUOT_W+1];
    logic [QUOT_W-1:0] dv_qy_reg    [QUOT_W+1];

    logic                     m_valid_reg;
    logic                     m_vis_reg;
    logic signed [QUOT_W:0]   m_nx_reg;
    logic signed [QUOT_W:0]   m_ny_reg;
    logic signed [QUOT_W:0]   m_nx_next;
    logic signed [QUOT_W:0]   m_ny_next;
    logic                     p_valid_reg;
    logic                     p_vis_reg;
    logic signed [PRD_W-1:0]  p_x_reg;
    logic signed [PRD_W-1:0]  p_y_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;
    result_t                  out_next;
    logic [MAG_W-1:0]         abs_x;
    logic [MAG_W-1:0]         abs_y;

    assign en    = !out_valid_reg || pop;
    assign q_pop = en && q_avail;
    assign empty = !out_valid_reg;
    assign result = out_reg;

    assign abs_x = q_head.cx[CLIP_W-1] ? MAG_W'(-q_head.cx) : q_head.cx[MAG_W-1:0];
    assign abs_y = q_head.cy[CLIP_W-1] ? MAG_W'(-q_head.cy) : q_head.cy[MAG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            b0_valid_reg    <= q_avail;
            dv_valid_reg[0] <= b0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_vis_reg     <= q_head.visible;
            b0_negx_reg    <= q_head.cx[CLIP_W-1];
            b0_negy_reg    <= q_head.cy[CLIP_W-1];
            b0_nx_reg      <= abs_x;
            b0_ny_reg      <= abs_y;
            b0_d_reg       <= q_head.cw[MAG_W-1:0];
            dv_vis_reg[0]  <= b0_vis_reg;
            dv_negx_reg[0] <= b0_negx_reg;
            dv_negy_reg[0] <= b0_negy_reg;
            dv_d_reg[0]    <= b0_d_reg;
            dv_rx_reg[0]   <= {b0_nx_reg, 16'b0};
            dv_ry_reg[0]   <= {b0_ny_reg, 16'b0};
            dv_ovfx_reg[0] <= EXT_W'({b0_nx_reg, 16'b0}) >= {b0_d_reg, QUOT_W'(0)};
            dv_ovfy_reg[0] <= EXT_W'({b0_ny_reg, 16'b0}) >= {b0_d_reg, QUOT_W'(0)};
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < QUOT_W; i++)
    begin : g_div
        localparam int K = QUOT_W - 1 - i;
        logic [EXT_W-1:0] dk;
        logic [EXT_W-1:0] rx_ext;
        logic [EXT_W-1:0] ry_ext;
        logic             gex;
        logic             gey;
        logic [EXT_W-1:0] rx_sub;
        logic [EXT_W-1:0] ry_sub;

        assign dk     = EXT_W'(dv_d_reg[i]) << K;
        assign rx_ext = EXT_W'(dv_rx_reg[i]);
        assign ry_ext = EXT_W'(dv_ry_reg[i]);
        assign gex    = rx_ext >= dk;
        assign gey    = ry_ext >= dk;
        assign rx_sub = rx_ext - dk;
        assign ry_sub = ry_ext - dk;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_vis_reg[i+1]  <= dv_vis_reg[i];
                dv_negx_reg[i+1] <= dv_negx_reg[i];
                dv_negy_reg[i+1] <= dv_negy_reg[i];
                dv_ovfx_reg[i+1] <= dv_ovfx_reg[i];
                dv_ovfy_reg[i+1] <= dv_ovfy_reg[i];
                dv_d_reg[i+1]    <= dv_d_reg[i];
                dv_rx_reg[i+1]   <= gex ? rx_sub[NUM_W-1:0] : dv_rx_reg[i];
                dv_ry_reg[i+1]   <= gey ? ry_sub[NUM_W-1:0] : dv_ry_reg[i];
                dv_qx_reg[i+1]   <= dv_qx_reg[i] | (QUOT_W'(gex) << K);
                dv_qy_reg[i+1]   <= dv_qy_reg[i] | (QUOT_W'(gey) << K);
            end
        end
    end

    always_comb
    begin
        logic [QUOT_W-1:0] mx;
        logic [QUOT_W-1:0] my;
        mx = (dv_ovfx_reg[QUOT_W] || dv_qx_reg[QUOT_W] > LIMIT) ? LIMIT : dv_qx_reg[QUOT_W];
        my = (dv_ovfy_reg[QUOT_W] || dv_qy_reg[QUOT_W] > LIMIT) ? LIMIT : dv_qy_reg[QUOT_W];
        m_nx_next = dv_negx_reg[QUOT_W] ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
        m_ny_next = dv_negy_reg[QUOT_W] ? -$signed({1'b0, my}) : $signed({1'b0, my});
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        sx = SUM_W'(p_x_reg) + OFF_X;
        sy = SUM_W'(p_y_reg) + OFF_Y;
        out_next.visible = p_vis_reg;
        priority if (!p_vis_reg)
            out_next.screen_x = '0;
        else if (sx > SMAX)
            out_next.screen_x = SMAX[COORD_W-1:0];
        else if (sx < SMIN)
            out_next.screen_x = SMIN[COORD_W-1:0];
        else
            out_next.screen_x = sx[COORD_W-1:0];
        priority if (!p_vis_reg)
            out_next.screen_y = '0;
        else if (sy > SMAX)
            out_next.screen_y = SMAX[COORD_W-1:0];
        else if (sy < SMIN)
            out_next.screen_y = SMIN[COORD_W-1:0];
        else
            out_next.screen_y = sy[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg   <= dv_valid_reg[QUOT_W];
            p_valid_reg   <= m_valid_reg;
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_vis_reg <= dv_vis_reg[QUOT_W];
            m_nx_reg  <= m_nx_next;
            m_ny_reg  <= m_ny_next;
            p_vis_reg <= m_vis_reg;
            p_x_reg   <= PRD_W'(KX) * PRD_W'(m_nx_reg);
            p_y_reg   <= PRD_W'(KY) * PRD_W'(m_ny_reg);
            out_reg   <= out_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.visible) |-> (out_reg.screen_x == 0 && out_reg.screen_y == 0))
        else $error("hidden point carries nonzero screen coordinates");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(p_valid_reg) && $stable(dv_valid_reg[QUOT_W])))
        else $error("divide pipeline moved while the result was stalled");
    a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_avail)
        else $error("queue popped while empty");
`endif

endmodule

@@ hw/rtl/world_to_screen_projection.sv @@
// Top level of the world-to-screen projection block with its coefficient registers.
//
// Points enter on a queue-style port: a request is taken when push is high and full is
// low. Results leave the same way: the oldest result is on result while empty is low,
// and it is taken when pop is high. Coefficients are written through the cfg channel,
// which is always ready; index k loads coefficient pair k, and higher indexes are ignored.
// The block takes one point per cycle while full is low. The path from accepted point to
// shown result runs through the three front stages, one queue slot and the back end,
// where the 41 quotient bits of the perspective divide each take one stage.
// When the receiver stalls, the back end holds in place, the four-entry queue fills,
// and then full rises. Reset empties all stages and clears the coefficients to zero.
module world_to_screen_projection
    import wtsp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1920,
    parameter int SCREEN_HEIGHT = 1080
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  point_t           point,
    output logic             empty,
    input  logic             pop,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] coeff_reg [NUM_PAIRS];
    qpush_t           q_req;
    logic             q_room;
    qent_t            q_head;
    logic             q_avail;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PAIRS; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_index < IDX_W'(NUM_PAIRS))
        begin
            coeff_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    wtsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coeff_pair (coeff_reg),
        .push       (push),
        .full       (full),
        .point      (point),
        .q_req      (q_req),
        .q_room     (q_room)
    );

    wtsp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_req   (q_req),
        .q_room  (q_room),
        .q_head  (q_head),
        .q_avail (q_avail),
        .q_pop   (q_pop)
    );

    wtsp_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_avail (q_avail),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
